// ===== rtl/hypotenuse_to_sixteenths_unit_macros.svh =====
// Assertion macros shared by the hypotenuse unit RTL.
`ifndef HYPOTENUSE_TO_SIXTEENTHS_UNIT_MACROS_SVH
`define HYPOTENUSE_TO_SIXTEENTHS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked during reset
`define HTSU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset
`define HTSU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/htsu_pkg.sv =====
// Shared widths, types, ladder constants and functions for the hypotenuse unit.
`default_nettype none

package htsu_pkg;

    localparam int INCH_BITS          = 12;
    localparam int ROOT_FRACTION_BITS = 16;

    // leg in sixteenths, its square, the sum of two squares
    localparam int LEG_W       = INCH_BITS + 4;
    localparam int SQ_W        = 2 * LEG_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int SUM_PAIRS   = (SUM_W + 1) / 2;
    localparam int EXTRA_PAIRS = ROOT_FRACTION_BITS - 4;
    localparam int RAD_W       = 2 * SUM_PAIRS;

    // one root cell per result bit
    localparam int ROOT_STEPS = SUM_PAIRS + EXTRA_PAIRS;
    localparam int Q_W        = ROOT_STEPS;
    localparam int R_W        = Q_W + 1;
    localparam int RP_W       = R_W + 2;

    // result fields
    localparam int HYP_INCH_W = Q_W - ROOT_FRACTION_BITS;
    localparam int CODE_W     = 4;

    // ladder
    localparam int LADDER_SCALE = 10000;
    localparam int SCALE_W      = 14;
    localparam int IDX_W        = 14;
    localparam int PROD_W       = ROOT_FRACTION_BITS + SCALE_W;
    localparam int NUM_RUNGS    = 15;
    localparam logic [IDX_W-1:0] CARRY_LIMIT = IDX_W'(9700);
    localparam logic [IDX_W-1:0] RUNGS [NUM_RUNGS] = '{
        IDX_W'(311),  IDX_W'(926),  IDX_W'(1561), IDX_W'(2181), IDX_W'(2811),
        IDX_W'(3431), IDX_W'(4061), IDX_W'(4681), IDX_W'(5311), IDX_W'(5931),
        IDX_W'(6561), IDX_W'(7181), IDX_W'(7811), IDX_W'(8431), IDX_W'(9061)
    };

    // stream data widths, whole bytes
    localparam int IN_TDATA_W  = ((2 * LEG_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = HYP_INCH_W + CODE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // partial root travelling along the cell row
    typedef struct packed {
        logic             valid;
        logic [RAD_W-1:0] rad;
        logic [Q_W-1:0]   q;
        logic [R_W-1:0]   r;
    } root_lane_t;

    // finished result
    typedef struct packed {
        logic                  valid;
        logic [HYP_INCH_W-1:0] inches;
        logic [CODE_W-1:0]     sixteenths;
    } hyp_result_t;

    // number of rungs at or below the index
    function automatic logic [CODE_W-1:0] ladder_code(input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < NUM_RUNGS; i++)
        begin
            if (idx >= RUNGS[i])
            begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/htsu_front.sv =====
// Front stages: form both legs, square them, add the squares.
`default_nettype none

module htsu_front
    import htsu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [INCH_BITS-1:0] leg_a_inches,
    input  wire logic [3:0]           leg_a_sixteenths,
    input  wire logic [INCH_BITS-1:0] leg_b_inches,
    input  wire logic [3:0]           leg_b_sixteenths,
    output root_lane_t                lane
);

    logic [LEG_W-1:0] leg_a;
    logic [LEG_W-1:0] leg_b;
    logic [SQ_W-1:0]  sq_a_reg;
    logic [SQ_W-1:0]  sq_a_next;
    logic [SQ_W-1:0]  sq_b_reg;
    logic [SQ_W-1:0]  sq_b_next;
    logic             sq_valid_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             sum_valid_reg;

    // form legs in sixteenths and square them
    assign leg_a     = {leg_a_inches, leg_a_sixteenths};
    assign leg_b     = {leg_b_inches, leg_b_sixteenths};
    assign sq_a_next = SQ_W'(leg_a) * SQ_W'(leg_a);
    assign sq_b_next = SQ_W'(leg_b) * SQ_W'(leg_b);
    assign sum_next  = SUM_W'(sq_a_reg) + SUM_W'(sq_b_reg);

    // advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_a_reg <= sq_a_next;
            sq_b_reg <= sq_b_next;
            sum_reg  <= sum_next;
        end
    end

    // hand the radicand to the first root cell
    always_comb
    begin
        lane.valid = sum_valid_reg;
        lane.rad   = RAD_W'(sum_reg);
        lane.q     = '0;
        lane.r     = '0;
    end

endmodule

`default_nettype wire

// ===== rtl/htsu_root_cell.sv =====
// One restoring square-root cell: consumes two radicand bits, yields one root bit.
`default_nettype none

module htsu_root_cell
    import htsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire root_lane_t lane_in,
    output root_lane_t lane_out
);

    logic             valid_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [RAD_W-1:0] rad_next;
    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   q_next;
    logic [R_W-1:0]   r_reg;
    logic [R_W-1:0]   r_next;
    logic [RP_W-1:0]  rem_trial;
    logic [RP_W-1:0]  sub_val;

    // bring down the top pair and try to subtract 4q+1
    always_comb
    begin
        rem_trial = {lane_in.r, lane_in.rad[RAD_W-1 -: 2]};
        sub_val   = RP_W'({lane_in.q, 2'b01});
        rad_next  = {lane_in.rad[RAD_W-3:0], 2'b00};
        if (rem_trial >= sub_val)
        begin
            r_next = R_W'(rem_trial - sub_val);
            q_next = {lane_in.q[Q_W-2:0], 1'b1};
        end
        else
        begin
            r_next = R_W'(rem_trial);
            q_next = {lane_in.q[Q_W-2:0], 1'b0};
        end
    end

    // hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= lane_in.valid;
        end
    end

    // hold partial root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= rad_next;
            q_reg   <= q_next;
            r_reg   <= r_next;
        end
    end

    always_comb
    begin
        lane_out.valid = valid_reg;
        lane_out.rad   = rad_reg;
        lane_out.q     = q_reg;
        lane_out.r     = r_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/htsu_ladder.sv =====
// Ladder stage: scale the root fraction, map it to a sixteenths code, apply carry.
`default_nettype none

module htsu_ladder
    import htsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire root_lane_t lane_in,
    output hyp_result_t res
);

    logic                  valid_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [HYP_INCH_W-1:0] whole_reg;
    logic [IDX_W-1:0]      idx;

    assign prod_next = PROD_W'(lane_in.q[ROOT_FRACTION_BITS-1:0])
                       * PROD_W'(LADDER_SCALE);

    // hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= lane_in.valid;
        end
    end

    // hold scaled fraction and whole inches
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            whole_reg <= lane_in.q[Q_W-1:ROOT_FRACTION_BITS];
        end
    end

    // look up code, carry into the next inch near the top
    always_comb
    begin
        idx       = IDX_W'(prod_reg[PROD_W-1:ROOT_FRACTION_BITS]);
        res.valid = valid_reg;
        if (idx > CARRY_LIMIT)
        begin
            res.inches     = whole_reg + 1'b1;
            res.sixteenths = '0;
        end
        else
        begin
            res.inches     = whole_reg;
            res.sixteenths = ladder_code(idx);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hypotenuse_to_sixteenths_unit.sv =====
// Top level: hypotenuse of two legs in inches and sixteenths, rounded to a sixteenths code.
//
//  channel   | direction | request contents (low bit up)
//  ----------+-----------+----------------------------------------------------------
//  s_axis    | in        | leg_a_inches, leg_a_sixteenths, leg_b_inches, leg_b_sixteenths
//  m_axis    | out       | hypot_inches, hypot_sixteenths, zero pad
//
// One request per cycle sustained while the skid register is empty; a request accepted
// shows on m_axis_tvalid through 33 register stages: two front stages (squares, sum), one
// root cell per result bit (29 cells), one ladder stage and the output register.
// Reset clears all valid flags; payload registers are not reset.
// A skid register behind the output holds one request while m_axis stalls; the
// cell row freezes only once the skid register is full.
`default_nettype none
`include "hypotenuse_to_sixteenths_unit_macros.svh"

module hypotenuse_to_sixteenths_unit
    import htsu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // leg_a_inches, leg_a_sixteenths, leg_b_inches, leg_b_sixteenths
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // hypot_inches, hypot_sixteenths, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    root_lane_t  lanes [ROOT_STEPS+1];
    hyp_result_t lad_res;
    logic        en;

    logic                  out_valid_reg;
    logic [HYP_INCH_W-1:0] out_inches_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic                  skid_valid_reg;
    logic [HYP_INCH_W-1:0] skid_inches_reg;
    logic [CODE_W-1:0]     skid_code_reg;

    // pipeline advances whenever the skid register is free
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    htsu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (s_axis_tvalid),
        .leg_a_inches     (s_axis_tdata[INCH_BITS-1:0]),
        .leg_a_sixteenths (s_axis_tdata[LEG_W-1:INCH_BITS]),
        .leg_b_inches     (s_axis_tdata[LEG_W+INCH_BITS-1:LEG_W]),
        .leg_b_sixteenths (s_axis_tdata[2*LEG_W-1:LEG_W+INCH_BITS]),
        .lane             (lanes[0])
    );

    // row of root cells, one result bit each
    for (genvar g = 0; g < ROOT_STEPS; g++)
    begin : g_cell
        htsu_root_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .lane_in  (lanes[g]),
            .lane_out (lanes[g+1])
        );
    end

    htsu_ladder u_ladder (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .lane_in (lanes[ROOT_STEPS]),
        .res     (lad_res)
    );

    // output and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en && lad_res.valid)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (en && lad_res.valid)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_inches_reg <= lad_res.inches;
                skid_code_reg   <= lad_res.sixteenths;
            end
            else
            begin
                out_inches_reg <= lad_res.inches;
                out_code_reg   <= lad_res.sixteenths;
            end
        end
        else if (m_axis_tready && skid_valid_reg)
        begin
            out_inches_reg <= skid_inches_reg;
            out_code_reg   <= skid_code_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_code_reg, out_inches_reg};

    `HTSU_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid full with output empty")
    `HTSU_ASSERT_NEXT(a_stall_fills_skid,
        en && lad_res.valid && out_valid_reg && !m_axis_tready, skid_valid_reg,
        "stalled result not caught by skid")
    `HTSU_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_axis_tready,
        !skid_valid_reg && out_valid_reg, "skid did not drain on ready")

endmodule

`default_nettype wire
